// ===== rtl/raw_pixel_stream_to_rgb888_assert.svh =====
// Assertion macros shared by the checker of the raw pixel stream converter.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RAW_PIXEL_STREAM_TO_RGB888_ASSERT_SVH
`define RAW_PIXEL_STREAM_TO_RGB888_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define RPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rps2rgb check failed in the same cycle");

// Next-cycle implication, off while reset is high.
`define RPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rps2rgb check failed one cycle later");

// Next-cycle implication that also holds through reset.
`define RPS_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rps2rgb check failed after reset");

`endif

// ===== rtl/rps2rgb_pkg.sv =====
// Package for the raw pixel stream to RGB888 converter.
// Holds field widths, register indexes and the configuration struct; no dependencies.
`default_nettype none

package rps2rgb_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int STRIDE_W   = 16;
  localparam int PBYTES_W   = 4;
  localparam int BYTE_W     = 8;
  localparam int COLOR_W    = 24;
  localparam int OFFSET_W   = 28;
  localparam int ROWBASE_W  = 29;
  localparam int PRODUCT_W  = COORD_W + PBYTES_W;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
  localparam logic [1:0]       PAD_BYTES = 2'd3;
  localparam logic [1:0]       NEED_RGB555 = 2'd2;
  localparam logic [1:0]       NEED_BGR24 = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT_MODE      = 3'd0,
    REG_FRAME_WIDTH      = 3'd1,
    REG_FRAME_HEIGHT     = 3'd2,
    REG_LINE_STRIDE      = 3'd3,
    REG_DEST_PIXEL_BYTES = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    FMT_RGB555 = 1'b0,
    FMT_BGR24  = 1'b1
  } format_t;

  typedef struct packed {
    format_t               format_mode;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic [STRIDE_W-1:0]   line_stride;
    logic [PBYTES_W-1:0]   dest_pixel_bytes;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rps2rgb_if.sv =====
// Stream interfaces of the converter: raw bytes in, converted pixels out.
// Depends on rps2rgb_pkg for the payload widths.
`default_nettype none

interface rps2rgb_byte_if;
  logic                             valid;
  logic                             ready;
  logic [rps2rgb_pkg::BYTE_W-1:0]   raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

interface rps2rgb_pix_if;
  logic                              valid;
  logic                              ready;
  logic [rps2rgb_pkg::COLOR_W-1:0]   rgb_word;
  logic [rps2rgb_pkg::COORD_W-1:0]   pixel_x;
  logic [rps2rgb_pkg::COORD_W-1:0]   pixel_y;
  logic [rps2rgb_pkg::OFFSET_W-1:0]  byte_offset;
  logic                              last_pixel;

  modport source (output valid, output rgb_word, output pixel_x, output pixel_y,
                  output byte_offset, output last_pixel, input ready);
  modport sink (input valid, input rgb_word, input pixel_x, input pixel_y,
                input byte_offset, input last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/raw_pixel_stream_to_rgb888.sv =====
// A byte is taken into the input register and then converted by the conversion stage, which
// registers its pixel beat; the beat is offered once the last byte of its pixel has passed both.
// Throughput: one byte per cycle while the output is taken; a stalled pixel beat holds the
// conversion stage, and the input register takes at most one more byte before stalling.
// Reset (synchronous, active high) clears the counters, the held bytes, both stage valid
// flags and the registers to format 0, size 1 by 1, stride 0, pixel bytes 4.
`default_nettype none

module raw_pixel_stream_to_rgb888 (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [rps2rgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rps2rgb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rps2rgb_byte_if.sink                            raw_in,
  rps2rgb_pix_if.source                           pix_out
);
  import rps2rgb_pkg::*;

  cfg_t cfg;

  rps2rgb_byte_if held_beat ();

  rps2rgb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rps2rgb_in_reg u_in_reg (
    .clk  (clk),
    .rst  (rst),
    .up   (raw_in),
    .down (held_beat)
  );

  rps2rgb_convert u_convert (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_beat (held_beat),
    .out_pix (pix_out)
  );

endmodule

`default_nettype wire

// ===== rtl/rps2rgb_cfg.sv =====
// Configuration register file of the converter, with clamping of the image size.
// Depends on rps2rgb_pkg.
`default_nettype none

module rps2rgb_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [rps2rgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rps2rgb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rps2rgb_pkg::cfg_t                       cfg
);
  import rps2rgb_pkg::*;

  format_t               format_mode;
  logic [DIM_W-1:0]      frame_width;
  logic [DIM_W-1:0]      frame_height;
  logic [STRIDE_W-1:0]   line_stride;
  logic [PBYTES_W-1:0]   dest_pixel_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode      <= FMT_RGB555;
      frame_width      <= DIM_W'(1);
      frame_height     <= DIM_W'(1);
      line_stride      <= '0;
      dest_pixel_bytes <= PBYTES_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FORMAT_MODE:      format_mode      <= format_t'(cfg_wdata[0]);
        REG_FRAME_WIDTH:      frame_width      <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:     frame_height     <= cfg_wdata[DIM_W-1:0];
        REG_LINE_STRIDE:      line_stride      <= cfg_wdata[STRIDE_W-1:0];
        REG_DEST_PIXEL_BYTES: dest_pixel_bytes <= cfg_wdata[PBYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_DIM_V) begin
      r = MAX_DIM_V;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    cfg.format_mode      = format_mode;
    cfg.width            = clamp_dim(frame_width);
    cfg.height           = clamp_dim(frame_height);
    cfg.line_stride      = line_stride;
    cfg.dest_pixel_bytes = dest_pixel_bytes;
  end

endmodule

`default_nettype wire

// ===== rtl/rps2rgb_in_reg.sv =====
// Input register of the converter: holds one raw byte beat for the conversion stage.
// Depends on rps2rgb_pkg and the stream interfaces.
`default_nettype none

module rps2rgb_in_reg (
  input  wire logic    clk,
  input  wire logic    rst,
  rps2rgb_byte_if.sink   up,
  rps2rgb_byte_if.source down
);
  import rps2rgb_pkg::*;

  logic              valid;
  logic [BYTE_W-1:0] raw_byte;

  assign up.ready      = !valid || down.ready;
  assign down.valid    = valid;
  assign down.raw_byte = raw_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up.ready) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      raw_byte <= up.raw_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rps2rgb_convert.sv =====
// Conversion stage: byte assembly, padding skip, position counters and result register.
// Depends on rps2rgb_pkg and the stream interfaces.
`default_nettype none

module rps2rgb_convert (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire rps2rgb_pkg::cfg_t cfg,
  rps2rgb_byte_if.sink      in_beat,
  rps2rgb_pix_if.source     out_pix
);
  import rps2rgb_pkg::*;

  logic [15:0]          byte_hold, byte_hold_next;
  logic [1:0]           byte_phase, byte_phase_next;
  logic [COORD_W-1:0]   column_count, column_count_next;
  logic [COORD_W-1:0]   row_count, row_count_next;
  logic [1:0]           pad_remaining, pad_remaining_next;
  logic [ROWBASE_W-1:0] row_base_offset, row_base_offset_next;

  logic                 out_valid;
  logic [COLOR_W-1:0]   out_color;
  logic [COORD_W-1:0]   out_x;
  logic [COORD_W-1:0]   out_y;
  logic [OFFSET_W-1:0]  out_offset;
  logic                 out_last;

  logic                 advance;
  logic [1:0]           need;
  logic [2:0]           phase_inc;
  logic                 is_pad;
  logic                 partial;
  logic [BYTE_W-1:0]    cur;
  logic [15:0]          c16;
  logic [COLOR_W-1:0]   color;
  logic [DIM_W-1:0]     col_inc;
  logic [DIM_W-1:0]     row_inc;
  logic                 row_end;
  logic                 last;
  logic [PRODUCT_W-1:0] product;
  logic [ROWBASE_W-1:0] offset_sum;
  logic                 emit;

  assign in_beat.ready = !out_valid || out_pix.ready;
  assign advance       = in_beat.valid && in_beat.ready;
  assign cur           = in_beat.raw_byte;

  always_comb begin
    need       = (cfg.format_mode == FMT_BGR24) ? NEED_BGR24 : NEED_RGB555;
    phase_inc  = {1'b0, byte_phase} + 3'd1;
    is_pad     = pad_remaining != 2'd0;
    partial    = !is_pad && (phase_inc < {1'b0, need});

    c16 = {cur, byte_hold[7:0]};
    if (cfg.format_mode == FMT_BGR24) begin
      color = {cur, byte_hold};
    end else begin
      color = {c16[14:10], 3'b000, c16[9:5], 3'b000, c16[4:0], 3'b000};
    end

    col_inc    = {1'b0, column_count} + DIM_W'(1);
    row_inc    = {1'b0, row_count} + DIM_W'(1);
    row_end    = col_inc >= cfg.width;
    last       = row_end && (row_inc >= cfg.height);
    product    = column_count * cfg.dest_pixel_bytes;
    offset_sum = row_base_offset + ROWBASE_W'(product);
    emit       = !is_pad && !partial && (cfg.line_stride != '0) &&
                 (cfg.dest_pixel_bytes != '0);

    byte_hold_next       = byte_hold;
    byte_phase_next      = byte_phase;
    column_count_next    = column_count;
    row_count_next       = row_count;
    pad_remaining_next   = pad_remaining;
    row_base_offset_next = row_base_offset;

    if (is_pad) begin
      pad_remaining_next = pad_remaining - 2'd1;
    end else if (partial) begin
      if (byte_phase == 2'd0) begin
        byte_hold_next = {8'h00, cur};
      end else begin
        byte_hold_next = {cur, byte_hold[7:0]};
      end
      byte_phase_next = phase_inc[1:0];
    end else begin
      byte_hold_next  = '0;
      byte_phase_next = 2'd0;
      if (row_end) begin
        column_count_next = '0;
        if (cfg.format_mode == FMT_BGR24 && cfg.width[0]) begin
          pad_remaining_next = PAD_BYTES;
        end
        if (last) begin
          row_count_next       = '0;
          row_base_offset_next = '0;
        end else begin
          row_count_next       = row_inc[COORD_W-1:0];
          row_base_offset_next = row_base_offset + ROWBASE_W'(cfg.line_stride);
        end
      end else begin
        column_count_next = col_inc[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_hold       <= '0;
      byte_phase      <= 2'd0;
      column_count    <= '0;
      row_count       <= '0;
      pad_remaining   <= 2'd0;
      row_base_offset <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        byte_hold       <= byte_hold_next;
        byte_phase      <= byte_phase_next;
        column_count    <= column_count_next;
        row_count       <= row_count_next;
        pad_remaining   <= pad_remaining_next;
        row_base_offset <= row_base_offset_next;
      end
      if (in_beat.ready) begin
        out_valid <= advance && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_color  <= color;
      out_x      <= column_count;
      out_y      <= row_count;
      out_offset <= offset_sum[OFFSET_W-1:0];
      out_last   <= last;
    end
  end

  assign out_pix.valid       = out_valid;
  assign out_pix.rgb_word    = out_color;
  assign out_pix.pixel_x     = out_x;
  assign out_pix.pixel_y     = out_y;
  assign out_pix.byte_offset = out_offset;
  assign out_pix.last_pixel  = out_last;

endmodule

`default_nettype wire

// ===== rtl/rps2rgb_checker.sv =====
// Port-level checker of the converter and its bind to the top level.
// Depends on rps2rgb_pkg and raw_pixel_stream_to_rgb888_assert.svh.
`default_nettype none
`include "raw_pixel_stream_to_rgb888_assert.svh"

module rps2rgb_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [rps2rgb_pkg::COLOR_W-1:0]   rgb_word,
  input wire logic [rps2rgb_pkg::COORD_W-1:0]   pixel_x,
  input wire logic [rps2rgb_pkg::COORD_W-1:0]   pixel_y,
  input wire logic [rps2rgb_pkg::OFFSET_W-1:0]  byte_offset,
  input wire logic                              last_pixel
);
  import rps2rgb_pkg::*;

  logic [COLOR_W+2*COORD_W+OFFSET_W:0] beat_payload;

  assign beat_payload = {rgb_word, pixel_x, pixel_y, byte_offset, last_pixel};

  // A stalled pixel beat stays and keeps its payload.
  `RPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RPS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(beat_payload))

  // Reset leaves no pixel beat pending.
  `RPS_ASSERT_RESET(a_reset_empty, rst, !out_valid)

  // The first pixel of the first row always lands at the start of the buffer.
  `RPS_ASSERT_NOW(a_origin_offset, out_valid && pixel_x == '0 && pixel_y == '0, byte_offset == '0)

endmodule

bind raw_pixel_stream_to_rgb888 rps2rgb_checker u_rps2rgb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .rgb_word    (pix_out.rgb_word),
  .pixel_x     (pix_out.pixel_x),
  .pixel_y     (pix_out.pixel_y),
  .byte_offset (pix_out.byte_offset),
  .last_pixel  (pix_out.last_pixel)
);

`default_nettype wire

// ===== tb/sv/tb_raw_pixel_stream_to_rgb888.sv =====
// Self-checking testbench for raw_pixel_stream_to_rgb888: raw bytes in, RGB888 pixel beats out.
// Uses rps2rgb_pkg and the rps2rgb_byte_if / rps2rgb_pix_if stream interfaces.
// A directed table runs first, then random register settings and byte streams with stalls.
module tb_raw_pixel_stream_to_rgb888;
  import rps2rgb_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 2;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_GAP = 6;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int RANDOM_BYTES = 430;
  localparam int TIMEOUT = 5_000_000;
  localparam int REG_SPARE_LO = 5;
  localparam int REG_SPARE_HI = 7;

  typedef struct packed {
    logic [COLOR_W-1:0]  color;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [OFFSET_W-1:0] offset;
    logic                last;
  } rgb_pixel_t;

  typedef struct {
    bit                  is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic [BYTE_W-1:0]   raw;
    bit                  typed;
    bit                  typed_beat;
    rgb_pixel_t          want;
  } stim_row_t;

  localparam rgb_pixel_t NO_PIXEL = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rps2rgb_byte_if raw_bytes ();
  rps2rgb_pix_if pixels ();

  raw_pixel_stream_to_rgb888 uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .raw_in    (raw_bytes),
    .pix_out   (pixels)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  cfg_t                cur_cfg;
  logic [15:0]         held_bytes = '0;
  logic [1:0]          bytes_in_pixel = '0;
  logic [COORD_W-1:0]  cur_col = '0;
  logic [COORD_W-1:0]  cur_row = '0;
  logic [1:0]          pad_left = '0;
  logic [ROWBASE_W-1:0] row_base = '0;

  rgb_pixel_t pending_pixels[$];
  stim_row_t  directed[$];
  int  mismatches = 0;
  bit  src_idle = 1'b1;
  bit  snk_idle = 1'b1;
  bit  hold_off_req = 1'b0;

  function automatic int dim_clamp(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Advances the converter state by one raw byte; returns 1 when a pixel beat is due.
  function automatic bit convert_byte(input logic [BYTE_W-1:0] b, output rgb_pixel_t pix);
    int need;
    int w;
    int h;
    logic [15:0] c16;
    logic [31:0] sum;
    bit row_end;
    pix = NO_PIXEL;
    need = (cur_cfg.format_mode == FMT_BGR24) ? 3 : 2;
    w = dim_clamp(cur_cfg.width);
    h = dim_clamp(cur_cfg.height);
    if (pad_left != 0) begin
      pad_left = pad_left - 2'd1;
      return 1'b0;
    end
    if (int'(bytes_in_pixel) + 1 < need) begin
      if (bytes_in_pixel == 0) begin
        held_bytes = {8'h00, b};
      end else begin
        held_bytes = {b, held_bytes[7:0]};
      end
      bytes_in_pixel = bytes_in_pixel + 2'd1;
      return 1'b0;
    end
    if (cur_cfg.format_mode == FMT_RGB555) begin
      c16 = {b, held_bytes[7:0]};
      pix.color = {c16[14:10], 3'b000, c16[9:5], 3'b000, c16[4:0], 3'b000};
    end else begin
      pix.color = {b, held_bytes};
    end
    bytes_in_pixel = '0;
    held_bytes = '0;
    pix.x = cur_col;
    pix.y = cur_row;
    sum = 32'(row_base) + 32'(cur_col) * 32'(cur_cfg.dest_pixel_bytes);
    pix.offset = sum[OFFSET_W-1:0];
    row_end = int'(cur_col) + 1 >= w;
    pix.last = row_end && (int'(cur_row) + 1 >= h);
    if (row_end) begin
      cur_col = '0;
      if (cur_cfg.format_mode == FMT_BGR24 && w[0]) pad_left = PAD_BYTES;
      if (pix.last) begin
        cur_row = '0;
        row_base = '0;
      end else begin
        cur_row = cur_row + 1'b1;
        row_base = row_base + ROWBASE_W'(cur_cfg.line_stride);
      end
    end else begin
      cur_col = cur_col + 1'b1;
    end
    return cur_cfg.line_stride != 0 && cur_cfg.dest_pixel_bytes != 0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_pixel(input rgb_pixel_t got);
    rgb_pixel_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("unexpected pixel beat, color", 32'(got.color), 32'd0);
    end else begin
      want = pending_pixels.pop_front();
      if (got.color !== want.color) report_mismatch("rgb_word", 32'(got.color), 32'(want.color));
      if (got.x !== want.x) report_mismatch("pixel_x", 32'(got.x), 32'(want.x));
      if (got.y !== want.y) report_mismatch("pixel_y", 32'(got.y), 32'(want.y));
      if (got.offset !== want.offset) begin
        report_mismatch("byte_offset", 32'(got.offset), 32'(want.offset));
      end
      if (got.last !== want.last) report_mismatch("last_pixel", 32'(got.last), 32'(want.last));
    end
  endtask

  // Returns once no beat is outstanding and the pipeline has had time to empty.
  task automatic settle();
    @(negedge clk);
    raw_bytes.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FORMAT_MODE:      cur_cfg.format_mode = format_t'(data[0]);
      REG_FRAME_WIDTH:      cur_cfg.width = data[DIM_W-1:0];
      REG_FRAME_HEIGHT:     cur_cfg.height = data[DIM_W-1:0];
      REG_LINE_STRIDE:      cur_cfg.line_stride = data[STRIDE_W-1:0];
      REG_DEST_PIXEL_BYTES: cur_cfg.dest_pixel_bytes = data[PBYTES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input bit typed_beat,
                           input rgb_pixel_t typed_pix);
    int gap;
    bit beat;
    rgb_pixel_t pix;
    @(negedge clk);
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      raw_bytes.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw_bytes.valid = 1'b1;
    raw_bytes.raw_byte = b;
    do @(posedge clk); while (!raw_bytes.ready);
    beat = convert_byte(b, pix);
    if (typed) begin
      if (typed_beat) pending_pixels.push_back(typed_pix);
    end else if (beat) begin
      pending_pixels.push_back(pix);
    end
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{1'b1, idx, data, 8'h00, 1'b0, 1'b0, NO_PIXEL};
    directed.push_back(row);
  endtask

  task automatic add_byte(input logic [BYTE_W-1:0] raw, input bit typed, input bit typed_beat,
                          input rgb_pixel_t want);
    stim_row_t row;
    row = '{1'b0, '0, '0, raw, typed, typed_beat, want};
    directed.push_back(row);
  endtask

  initial begin : sink_side
    rgb_pixel_t got;
    int stall;
    pixels.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        pixels.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        pixels.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pixels.ready = 1'b1;
      do @(posedge clk); while (!pixels.valid);
      got.color = pixels.rgb_word;
      got.x = pixels.pixel_x;
      got.y = pixels.pixel_y;
      got.offset = pixels.byte_offset;
      got.last = pixels.last_pixel;
      check_pixel(got);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int bytes_sent;
    int w;
    int h;
    int per_pixel;
    int image_bytes;
    int n;
    bit hold_done;
    logic [CFG_DATA_W-1:0] data;
    raw_bytes.valid = 1'b0;
    raw_bytes.raw_byte = '0;
    cur_cfg.format_mode = FMT_RGB555;
    cur_cfg.width = DIM_W'(1);
    cur_cfg.height = DIM_W'(1);
    cur_cfg.line_stride = '0;
    cur_cfg.dest_pixel_bytes = PBYTES_W'(4);
    bytes_sent = 0;
    hold_done = 1'b0;

    // Out of reset the stride is zero, so no beat may come out.
    add_byte(8'hFF, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'h7F, 1'b1, 1'b0, NO_PIXEL);
    // A 2 by 2 RGB555 image: pure red, white, pure blue, and green with bit 15 set.
    add_write(REG_FORMAT_MODE, CFG_DATA_W'(FMT_RGB555));
    add_write(REG_FRAME_WIDTH, 16'd2);
    add_write(REG_FRAME_HEIGHT, 16'd2);
    add_write(REG_LINE_STRIDE, 16'd16);
    add_write(REG_DEST_PIXEL_BYTES, 16'd4);
    add_byte(8'h00, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'h7C, 1'b1, 1'b1, '{24'hF80000, 12'd0, 12'd0, 28'd0, 1'b0});
    add_byte(8'hFF, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'hFF, 1'b1, 1'b1, '{24'hF8F8F8, 12'd1, 12'd0, 28'd4, 1'b0});
    add_byte(8'h1F, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'h00, 1'b1, 1'b1, '{24'h0000F8, 12'd0, 12'd1, 28'd16, 1'b0});
    add_byte(8'hE0, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'h83, 1'b1, 1'b1, '{24'h00F800, 12'd1, 12'd1, 28'd20, 1'b1});
    // A single BGR24 pixel with odd width, followed by its three padding bytes.
    add_write(REG_FORMAT_MODE, CFG_DATA_W'(FMT_BGR24));
    add_write(REG_FRAME_WIDTH, 16'd1);
    add_write(REG_FRAME_HEIGHT, 16'd1);
    add_write(REG_LINE_STRIDE, 16'hFFFF);
    add_write(REG_DEST_PIXEL_BYTES, 16'd8);
    add_byte(8'h11, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'h22, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'h33, 1'b1, 1'b1, '{24'h332211, 12'd0, 12'd0, 28'd0, 1'b1});
    add_byte(8'hAA, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'h55, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'h00, 1'b1, 1'b0, NO_PIXEL);
    // Zero destination pixel size suppresses the beat.
    add_write(REG_FORMAT_MODE, CFG_DATA_W'(FMT_RGB555));
    add_write(REG_DEST_PIXEL_BYTES, 16'd0);
    add_byte(8'h12, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'h34, 1'b1, 1'b0, NO_PIXEL);
    // Zero width and height are taken as one.
    add_write(REG_FRAME_WIDTH, 16'd0);
    add_write(REG_FRAME_HEIGHT, 16'd0);
    add_write(REG_LINE_STRIDE, 16'd3);
    add_write(REG_DEST_PIXEL_BYTES, 16'd1);
    add_byte(8'hAB, 1'b1, 1'b0, NO_PIXEL);
    add_byte(8'hCD, 1'b1, 1'b1, '{24'h986858, 12'd0, 12'd0, 28'd0, 1'b1});
    // Oversized width and height clamp to the maximum; a spare index is ignored.
    add_write(REG_FRAME_WIDTH, 16'hFFFF);
    add_write(REG_FRAME_HEIGHT, 16'h1001);
    add_byte(8'h5A, 1'b0, 1'b0, NO_PIXEL);
    add_byte(8'hA5, 1'b0, 1'b0, NO_PIXEL);
    add_write(CFG_IDX_W'(REG_SPARE_LO), 16'hFFFF);
    add_byte(8'hC3, 1'b0, 1'b0, NO_PIXEL);
    add_byte(8'h3C, 1'b0, 1'b0, NO_PIXEL);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_byte(directed[i].raw, directed[i].typed, directed[i].typed_beat, directed[i].want);
      end
    end

    while (bytes_sent < RANDOM_BYTES) begin
      src_idle = $urandom_range(0, 3) != 0;
      snk_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 1) == 1) write_reg(REG_FORMAT_MODE, 16'($urandom));
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: data = '0;
          1: data = CFG_DATA_W'(MAX_DIM);
          2: data = 16'hFFFF;
          default: data = 16'($urandom_range(1, 7));
        endcase
        write_reg(REG_FRAME_WIDTH, data);
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: data = '0;
          1: data = CFG_DATA_W'(MAX_DIM);
          2: data = 16'h2001;
          default: data = 16'($urandom_range(1, 4));
        endcase
        write_reg(REG_FRAME_HEIGHT, data);
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 7))
          0: data = '0;
          1: data = 16'hFFFF;
          default: data = 16'($urandom_range(1, 65535));
        endcase
        write_reg(REG_LINE_STRIDE, data);
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: data = '0;
          1: data = 16'd8;
          2: data = 16'($urandom_range(9, 15));
          3: data = 16'hFFF0 | 16'($urandom_range(1, 8));
          default: data = 16'($urandom_range(1, 8));
        endcase
        write_reg(REG_DEST_PIXEL_BYTES, data);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
      end

      w = dim_clamp(cur_cfg.width);
      h = dim_clamp(cur_cfg.height);
      per_pixel = (cur_cfg.format_mode == FMT_BGR24) ? 3 : 2;
      image_bytes = w * per_pixel;
      if (cur_cfg.format_mode == FMT_BGR24 && w[0]) image_bytes += int'(PAD_BYTES);
      image_bytes = image_bytes * h;
      if (image_bytes <= 120 && $urandom_range(0, 3) != 0) begin
        n = image_bytes * $urandom_range(1, 2);
      end else begin
        n = $urandom_range(1, 40);
      end
      // One long output stall while bytes keep coming, so the block backs up.
      if (!hold_done && cur_cfg.line_stride != 0 && cur_cfg.dest_pixel_bytes != 0) begin
        hold_done = 1'b1;
        hold_off_req = 1'b1;
        src_idle = 1'b0;
        n = 60;
      end
      if (n > RANDOM_BYTES - bytes_sent) n = RANDOM_BYTES - bytes_sent;
      repeat (n) begin
        send_byte(8'($urandom), 1'b0, 1'b0, NO_PIXEL);
        bytes_sent++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("raw_pixel_stream_to_rgb888 verification clean");
    end else begin
      $display("raw_pixel_stream_to_rgb888 verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT;
    $display("raw_pixel_stream_to_rgb888 verification failed");
    $finish;
  end

endmodule
